/* rtl/cassette_carrier_bit_decoder_top_macros.svh */
`ifndef CASSETTE_CARRIER_BIT_DECODER_TOP_MACROS_SVH
`define CASSETTE_CARRIER_BIT_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define CCBD_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define CCBD_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

/* rtl/ccbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ccbd_pkg;

  typedef enum logic [1:0] {
    BAUD_600  = 2'd0,
    BAUD_1200 = 2'd1,
    BAUD_2400 = 2'd2,
    BAUD_300  = 2'd3
  } baud_e;

  typedef struct packed {
    logic data_bit;
    logic bit_error;
    logic from_hunt;
    logic last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  localparam int unsigned HIST_W = 16;
  localparam int unsigned HELD_W = 5;

  // zero, zero flipped, one, one flipped
  localparam logic [HIST_W-1:0] PAT_VAL [4][4] = '{
    '{16'h0033, 16'h00CC, 16'h0055, 16'h00AA},
    '{16'h0003, 16'h000C, 16'h0005, 16'h000A},
    '{16'h0003, 16'h0000, 16'h0001, 16'h0002},
    '{16'h3333, 16'hCCCC, 16'h5555, 16'hAAAA}
  };

  localparam logic [HELD_W-1:0] PAT_LEN [4] = '{5'd8, 5'd4, 5'd2, 5'd16};

  localparam logic [HIST_W-1:0] EDGE_VAL [4] = '{16'h0004, 16'h000B, 16'h0002, 16'h000D};

  localparam logic [HELD_W-1:0] EDGE_LEN = 5'd4;

  function automatic logic [HIST_W-1:0] len_mask(input logic [HELD_W-1:0] len);
    logic [HIST_W-1:0] m;
    if (len[4]) begin
      m = '1;
    end else begin
      m = (HIST_W'(1) << len[3:0]) - HIST_W'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/ccbd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ccbd_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               accept_i,
  input  wire               symbol_i,
  input  ccbd_pkg::baud_e   mode_i,
  output ccbd_pkg::push_t   push_o
);
  import ccbd_pkg::*;

  logic                locked_q, locked_d;
  logic                flip_q, flip_d;
  logic [HIST_W-1:0]   hist_q, hist_d;
  logic [HELD_W-1:0]   held_q, held_d;

  logic [HIST_W-1:0]   hist_n;
  logic [HELD_W-1:0]   held_n;
  logic                is_edge;
  logic [HELD_W-1:0]   hlen, tlen;
  logic [HIST_W-1:0]   hmask, tmask;
  logic [HIST_W-1:0]   w0;
  logic [HIST_W-1:0]   pv;
  logic                found;
  logic [3:0]          sel_p;
  logic [1:0]          sel_i;
  logic [HELD_W-1:0]   drop_n;
  logic                zero_hit, one_hit;
  push_t               push;

  always_comb begin
    if (held_q[4]) begin
      hist_n = {symbol_i, hist_q[HIST_W-1:1]};
      held_n = held_q;
    end else begin
      hist_n = hist_q | (HIST_W'(symbol_i) << held_q[3:0]);
      held_n = held_q + HELD_W'(1);
    end
  end

  // hunt: earliest start, then pattern order
  always_comb begin
    is_edge = (mode_i == BAUD_2400);
    hlen    = is_edge ? EDGE_LEN : PAT_LEN[mode_i];
    hmask   = len_mask(hlen);
    found   = 1'b0;
    sel_p   = '0;
    sel_i   = '0;
    pv      = '0;
    for (int p = HIST_W - 1; p >= 0; p--) begin
      for (int i = 3; i >= 0; i--) begin
        pv = is_edge ? EDGE_VAL[i] : PAT_VAL[mode_i][i];
        if (((6'(p) + 6'(hlen)) <= 6'(held_n)) && (((hist_n >> p) & hmask) == pv)) begin
          found = 1'b1;
          sel_p = 4'(p);
          sel_i = 2'(i);
        end
      end
    end
  end

  // locked compare on the oldest group
  always_comb begin
    tlen     = PAT_LEN[mode_i];
    tmask    = len_mask(tlen);
    w0       = hist_n & tmask;
    zero_hit = (w0 == PAT_VAL[mode_i][{1'b0, flip_q}]) ||
               (is_edge && (w0 == PAT_VAL[mode_i][{1'b0, ~flip_q}]));
    one_hit  = (w0 == PAT_VAL[mode_i][{1'b1, flip_q}]);
  end

  always_comb begin
    locked_d = locked_q;
    flip_d   = flip_q;
    drop_n   = '0;
    push     = '0;
    if (locked_q) begin
      if (held_n >= tlen) begin
        push.cnt            = 2'd1;
        push.r0.last_of_run = 1'b1;
        if (zero_hit) begin
          drop_n = tlen;
          if (is_edge) begin
            flip_d = ~flip_q;
          end
        end else if (one_hit) begin
          drop_n           = tlen;
          push.r0.data_bit = 1'b1;
        end else begin
          drop_n            = HELD_W'(1);
          locked_d          = 1'b0;
          push.r0.bit_error = 1'b1;
        end
      end
    end else if (found) begin
      locked_d          = 1'b1;
      flip_d            = sel_i[0];
      drop_n            = HELD_W'(sel_p) + hlen;
      push.r0.data_bit  = sel_i[1];
      push.r0.from_hunt = 1'b1;
      if (is_edge) begin
        push.cnt            = 2'd2;
        push.r1.data_bit    = ~sel_i[1];
        push.r1.from_hunt   = 1'b1;
        push.r1.last_of_run = 1'b1;
      end else begin
        push.cnt            = 2'd1;
        push.r0.last_of_run = 1'b1;
      end
    end
    if (drop_n >= held_n) begin
      hist_d = '0;
      held_d = '0;
    end else begin
      hist_d = hist_n >> drop_n;
      held_d = held_n - drop_n;
    end
  end

  always_comb begin
    push_o = push;
    if (!accept_i) begin
      push_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      flip_q   <= 1'b0;
      hist_q   <= '0;
      held_q   <= '0;
    end else if (accept_i) begin
      locked_q <= locked_d;
      flip_q   <= flip_d;
      hist_q   <= hist_d;
      held_q   <= held_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/ccbd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ccbd_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ccbd_pkg::push_t    push_i,
  input  wire                pop_i,
  output logic               room_o,
  output logic               valid_o,
  output ccbd_pkg::result_t  item_o
);
  import ccbd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    logic [AW-1:0] r;
    if (ptr == AW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = ptr + AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_nx   = ptr_inc(wr_q);
    valid_o = (cnt_q != '0);
    room_o  = (cnt_q <= CW'(Depth - 2));
    item_o  = mem_q[rd_q];
    rd_d    = (pop_i && valid_o) ? ptr_inc(rd_q) : rd_q;
    case (push_i.cnt)
      2'd1:    wr_d = wr_nx;
      2'd2:    wr_d = ptr_inc(wr_nx);
      default: wr_d = wr_q;
    endcase
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/ccbd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ccbd_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  ccbd_pkg::result_t  q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output ccbd_pkg::result_t  out_item_o
);
  import ccbd_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_item_q;

  always_comb begin
    pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
    out_valid_d = pop_o || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

/* rtl/cassette_carrier_bit_decoder_top.sv */
// channel   | valid       | flow control | payload
// ----------+-------------+--------------+---------------------------------------------
// symbol in | in_valid_i  | in_stall_o   | carrier_symbol_i
// bit out   | out_valid_o | out_stall_i  | data_bit_o bit_error_o from_hunt_o last_of_run_o
// config    | cfg_valid_i | cfg_ready_o  | cfg_data_i (baud mode)
//
// one symbol per cycle while in_stall_o is low; each is decoded in the cycle it is taken, results
// pass through the result queue and are then registered on the output
// a 2400 baud lock gives two bits for one symbol, drained one per cycle while out_stall_i is low
// in_stall_o rises when the result queue has fewer than two free slots
// reset clears lock, flip, history and baud mode (600 baud)
`timescale 1ns / 1ps
`default_nettype none
module cassette_carrier_bit_decoder_top #(
  parameter int unsigned QDepth = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        carrier_symbol_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       data_bit_o,
  output logic       bit_error_o,
  output logic       from_hunt_o,
  output logic       last_of_run_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire  [1:0] cfg_data_i
);
  import ccbd_pkg::*;

  baud_e   mode_q;
  logic    accept;
  logic    room, q_valid, pop;
  push_t   push;
  result_t q_item, out_item;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= BAUD_600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= baud_e'(cfg_data_i);
    end
  end

  ccbd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .symbol_i (carrier_symbol_i),
    .mode_i   (mode_q),
    .push_o   (push)
  );

  ccbd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ccbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  assign data_bit_o    = out_item.data_bit;
  assign bit_error_o   = out_item.bit_error;
  assign from_hunt_o   = out_item.from_hunt;
  assign last_of_run_o = out_item.last_of_run;

endmodule
`default_nettype wire

/* rtl/ccbd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "cassette_carrier_bit_decoder_top_macros.svh"
module ccbd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire       data_bit_o,
  input wire       bit_error_o,
  input wire       from_hunt_o,
  input wire       last_of_run_o
);

  logic err_ok;
  logic pair_ok;
  logic pair_take;
  logic pair_last;

  assign err_ok    = !data_bit_o && !from_hunt_o && last_of_run_o;
  assign pair_ok   = from_hunt_o && !bit_error_o;
  assign pair_take = out_valid_o && !out_stall_i && !last_of_run_o;
  assign pair_last = out_valid_o && from_hunt_o && last_of_run_o;

  `CCBD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output item dropped")

  `CCBD_ASSERT_NOW(a_err_form, out_valid_o && bit_error_o, err_ok, "bad error item")

  `CCBD_ASSERT_NOW(a_pair_hunt, out_valid_o && !last_of_run_o, pair_ok, "non-final item not from hunt")

  `CCBD_ASSERT_NEXT(a_pair_next, pair_take, pair_last, "second bit of pair missing")

endmodule

bind cassette_carrier_bit_decoder_top ccbd_checker u_ccbd_checker (.*);
`default_nettype wire

/* tb/sv/tb_cassette_carrier_bit_decoder_top.sv */
`timescale 1ns / 1ps
module tb_cassette_carrier_bit_decoder_top;
  import ccbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SLOT_ONE = 2;

  // zero, zero flipped, one, one flipped; bit k is the k-th oldest symbol
  localparam logic [15:0] GROUP_PAT [4][4] = '{
    '{16'h0033, 16'h00CC, 16'h0055, 16'h00AA},
    '{16'h0003, 16'h000C, 16'h0005, 16'h000A},
    '{16'h0003, 16'h0000, 16'h0001, 16'h0002},
    '{16'h3333, 16'hCCCC, 16'h5555, 16'hAAAA}
  };
  localparam int GROUP_LEN [4] = '{8, 4, 2, 16};
  localparam logic [15:0] EDGE_PAT [4] = '{16'h0004, 16'h000B, 16'h0002, 16'h000D};
  localparam int EDGE_LEN = 4;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       carrier_symbol_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_data_i = 2'd0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       data_bit_o;
  logic       bit_error_o;
  logic       from_hunt_o;
  logic       last_of_run_o;
  logic       cfg_ready_o;

  cassette_carrier_bit_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .carrier_symbol_i(carrier_symbol_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_bit_o      (data_bit_o),
    .bit_error_o     (bit_error_o),
    .from_hunt_o     (from_hunt_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder state as predicted
  baud_e       baud_m = BAUD_600;
  logic        lock_m = 1'b0;
  logic        flip_m = 1'b0;
  logic [15:0] hist_m = '0;
  int          held_m = 0;

  logic    symbol_queue [$];
  result_t expected_bits [$];

  int tx_idle = 0;
  int rx_idle = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int symbols_taken = 0;
  int bits_checked = 0;
  int hunt_locks = 0;
  int bit_errs = 0;
  int queued_total = 0;

  function automatic void drop_held(input int n);
    if (n >= held_m) begin
      hist_m = '0;
      held_m = 0;
    end else begin
      hist_m = hist_m >> n;
      held_m = held_m - n;
    end
  endfunction

  function automatic void push_bit(input logic d, input logic e, input logic h, input logic l);
    result_t r;
    r.data_bit = d;
    r.bit_error = e;
    r.from_hunt = h;
    r.last_of_run = l;
    expected_bits.push_back(r);
  endfunction

  function automatic void decode_symbol(input logic sym);
    int          len;
    int          pos;
    int          i;
    logic [15:0] mask;
    logic [15:0] w;
    logic [15:0] p;
    logic        at2400;
    logic        hit;
    logic        b;
    at2400 = (baud_m == BAUD_2400);
    if (held_m >= 16) begin
      hist_m = {sym, hist_m[15:1]};
    end else begin
      hist_m[held_m] = sym;
      held_m++;
    end
    if (!lock_m) begin
      len = at2400 ? EDGE_LEN : GROUP_LEN[int'(baud_m)];
      mask = (len >= 16) ? 16'hFFFF : 16'((1 << len) - 1);
      hit = 1'b0;
      for (pos = 0; pos + len <= held_m && !hit; pos++) begin
        w = (hist_m >> pos) & mask;
        for (i = 0; i < 4 && !hit; i++) begin
          p = at2400 ? EDGE_PAT[i] : GROUP_PAT[int'(baud_m)][i];
          if (w == p) begin
            hit = 1'b1;
            b = (i >= SLOT_ONE);
            flip_m = i[0];
            lock_m = 1'b1;
            hunt_locks++;
            drop_held(pos + len);
            if (at2400) begin
              push_bit(b, 1'b0, 1'b1, 1'b0);
              push_bit(!b, 1'b0, 1'b1, 1'b1);
            end else begin
              push_bit(b, 1'b0, 1'b1, 1'b1);
            end
          end
        end
      end
    end else begin
      len = GROUP_LEN[int'(baud_m)];
      if (held_m >= len) begin
        mask = (len >= 16) ? 16'hFFFF : 16'((1 << len) - 1);
        w = hist_m & mask;
        if (w == GROUP_PAT[int'(baud_m)][flip_m] ||
            (at2400 && w == GROUP_PAT[int'(baud_m)][!flip_m])) begin
          if (at2400) flip_m = !flip_m;
          drop_held(len);
          push_bit(1'b0, 1'b0, 1'b0, 1'b1);
        end else if (w == GROUP_PAT[int'(baud_m)][SLOT_ONE + flip_m]) begin
          drop_held(len);
          push_bit(1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          drop_held(1);
          lock_m = 1'b0;
          bit_errs++;
          push_bit(1'b0, 1'b1, 1'b0, 1'b1);
        end
      end
    end
  endfunction

  // symbol driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_symbol(carrier_symbol_i);
        symbols_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (symbol_queue.size() != 0 && $urandom_range(99) >= tx_idle) begin
          in_valid_i <= 1'b1;
          carrier_symbol_i <= symbol_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s at cycle %0d: expected bit %0d err %0d hunt %0d last %0d, got bit %0d err %0d hunt %0d last %0d",
               what, cycles, want.data_bit, want.bit_error, want.from_hunt, want.last_of_run,
               got.data_bit, got.bit_error, got.from_hunt, got.last_of_run);
    end
  endtask

  // bit monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {data_bit_o, bit_error_o, from_hunt_o, last_of_run_o};
        if (expected_bits.size() == 0) begin
          log_mismatch("unexpected bit", '0, got);
        end else begin
          want = expected_bits.pop_front();
          bits_checked++;
          if (got.data_bit !== want.data_bit || got.bit_error !== want.bit_error ||
              got.from_hunt !== want.from_hunt || got.last_of_run !== want.last_of_run) begin
            log_mismatch("bit mismatch", want, got);
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bits still expected", cycles, expected_bits.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_symbol(input logic s);
    symbol_queue.push_back(s);
    queued_total++;
  endtask

  task automatic queue_pattern(input logic [15:0] p, input int len);
    int k;
    for (k = 0; k < len; k++) queue_symbol(p[k]);
  endtask

  task automatic queue_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) queue_symbol(s[k] == "1");
  endtask

  // mostly well-formed bursts: a lock pattern then a run of bit groups
  task automatic queue_random_phase(input baud_e m, input int target);
    int start;
    int i;
    int n;
    int k;
    int f;
    int md;
    start = queued_total;
    md = int'(m);
    while (queued_total - start < target) begin
      if ($urandom_range(99) < 12) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) queue_symbol(1'($urandom_range(1)));
      end else begin
        i = $urandom_range(3);
        f = i % 2;
        if (m == BAUD_2400) queue_pattern(EDGE_PAT[i], EDGE_LEN);
        else queue_pattern(GROUP_PAT[md][i], GROUP_LEN[md]);
        n = (m == BAUD_300) ? $urandom_range(1, 3) : $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(1)) begin
            queue_pattern(GROUP_PAT[md][SLOT_ONE + f], GROUP_LEN[md]);
          end else begin
            queue_pattern(GROUP_PAT[md][f], GROUP_LEN[md]);
            if (m == BAUD_2400) f = 1 - f;
          end
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (symbol_queue.size() != 0 || in_valid_i || expected_bits.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_baud(input baud_e m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    baud_m = m;
    @(negedge clk_i);
  endtask

  initial begin
    baud_e phase_baud [9];
    int    p;
    phase_baud = '{BAUD_600, BAUD_300, BAUD_2400, BAUD_1200, BAUD_2400,
                   BAUD_300, BAUD_600, BAUD_1200, BAUD_2400};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full history with no match, then a lock at 1200
    write_baud(BAUD_1200);
    queue_text("00000000000000000");
    queue_text("1100");
    wait_drained();
    // switch to 2400 while locked
    write_baud(BAUD_2400);
    queue_text("1011");
    queue_text("0100");
    wait_drained();

    for (p = 0; p < 9; p++) begin
      if (p < 3) begin
        tx_idle = 30;
        rx_idle = 59;
      end else if (p < 6) begin
        tx_idle = 59;
        rx_idle = 30;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      write_baud(phase_baud[p]);
      queue_random_phase(phase_baud[p], 45);
      if (p == 6) hold_req++;
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    $display("covered %0d symbols over all four baud modes with idle and hold-off phases",
             symbols_taken);
    $display("checked %0d bits: %0d hunt locks, %0d decode errors", bits_checked, hunt_locks,
             bit_errs);
    if (errors == 0 && expected_bits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
